// ===== rtl/tsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

  localparam int DEF_PAGE_TILES  = 32;
  localparam int DEF_MASK_TILES  = 64;
  localparam int DEF_BLOCK_COUNT = 256;

  localparam logic [63:0] CODE_BASE = 64'hFF00;
  localparam int WORD_BITS = 16;

  typedef enum logic [1:0] {
    REQ_RESERVE = 2'd0,
    REQ_MARK    = 2'd1,
    REQ_READ    = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  typedef struct packed {
    logic take_in;
    logic sweep;
    logic finish;
  } tsp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic sweep_last;
  } tsp_stat_t;

  function automatic logic [63:0] encode_word(input logic [WORD_BITS-1:0] w);
    logic [63:0] code;
    code = CODE_BASE;
    for (int j = 0; j < WORD_BITS; j++) begin
      code[16 + 3 * j] = w[j];
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tsp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_req_type,
  input  tsp_pkg::tsp_stat_t stat,
  output tsp_pkg::tsp_cmd_t  cmd,
  output logic               in_ready
);
  import tsp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIN,
    S_SWEEP
  } state_t;

  state_t state_r;
  logic   from_req_r;
  logic   accept;

  assign in_ready = (state_r == S_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.take_in = accept;
    cmd.sweep   = (state_r == S_SWEEP);
    cmd.finish  = (state_r == S_FIN) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_SWEEP;
      from_req_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (req_t'(in_req_type)) inside
              REQ_RESERVE: state_r <= S_IDLE;
              REQ_MARK, REQ_READ: state_r <= S_FIN;
              REQ_CLEAR: begin
                state_r    <= S_SWEEP;
                from_req_r <= 1'b1;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_FIN: begin
          if (stat.out_free) begin
            state_r <= S_IDLE;
          end
        end
        S_SWEEP: begin
          if (stat.sweep_last) begin
            state_r    <= from_req_r ? S_FIN : S_IDLE;
            from_req_r <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tsp_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsp_dp #(
  parameter int PAGE_TILES  = tsp_pkg::DEF_PAGE_TILES,
  parameter int MASK_TILES  = tsp_pkg::DEF_MASK_TILES,
  parameter int BLOCK_COUNT = tsp_pkg::DEF_BLOCK_COUNT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tsp_pkg::tsp_cmd_t  cmd,
  output tsp_pkg::tsp_stat_t stat,
  input  logic [1:0]         in_req_type,
  input  logic [4:0]         in_region_width,
  input  logic [4:0]         in_region_height,
  input  logic [1:0]         in_level,
  input  logic [4:0]         in_tile_x,
  input  logic [4:0]         in_tile_y,
  input  logic [7:0]         in_block_index,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_status,
  output logic [4:0]         out_place_x,
  output logic [4:0]         out_place_y,
  output logic [63:0]        out_block_code
);
  import tsp_pkg::*;

  localparam int PMAX       = (PAGE_TILES > 31) ? PAGE_TILES : 31;
  localparam int PW         = $clog2(PMAX + 1);
  localparam int SW         = $clog2(PMAX + 32);
  localparam int CW         = $clog2(PAGE_TILES + 32);
  localparam int ROW_WORDS  = MASK_TILES / 4;
  localparam int WORD_COUNT = ROW_WORDS * ROW_WORDS;
  localparam int AW         = $clog2(WORD_COUNT);
  localparam int IW         = CW + $clog2(ROW_WORDS + 1);
  localparam int XW0        = (IW > AW) ? IW : AW;
  localparam int XW         = (XW0 > 8) ? XW0 : 8;

  logic [PW-1:0] pack_col_r, pack_row_r, pack_row_high_r;
  logic [PW-1:0] pack_col_nxt, pack_row_nxt, pack_row_high_nxt;

  logic [WORD_BITS-1:0] mask_mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rd_data_r;
  logic [AW-1:0]        cnt_r;
  logic [AW-1:0]        addr_r;
  logic [3:0]           bit_r;
  logic                 hit_r;
  req_t                 req_r;

  logic [SW-1:0] end_x0, end_x, end_y;
  logic [PW-1:0] col_use, row_use;
  logic          wrap, fail;
  logic [CW-1:0] mx, my;
  logic [IW-1:0] idx;
  logic [XW-1:0] idx_ext, bi_ext;
  logic          mark_hit, read_hit;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  logic [WORD_BITS-1:0] wd;
  logic          load_res, load_fin;

  assign stat.out_free   = !out_valid || out_ready;
  assign stat.sweep_last = (cnt_r == AW'(WORD_COUNT - 1));

  always_comb begin
    end_x0  = SW'(pack_col_r) + SW'(in_region_width);
    wrap    = end_x0 > SW'(PAGE_TILES);
    col_use = wrap ? '0 : pack_col_r;
    row_use = wrap ? pack_row_high_r : pack_row_r;
    end_x   = wrap ? SW'(in_region_width) : end_x0;
    end_y   = SW'(row_use) + SW'(in_region_height);
    fail    = end_y > SW'(PAGE_TILES);

    pack_col_nxt      = col_use;
    pack_row_nxt      = row_use;
    pack_row_high_nxt = pack_row_high_r;
    if (!fail) begin
      pack_col_nxt = end_x[PW-1:0];
      if (end_y > SW'(pack_row_high_r)) begin
        pack_row_high_nxt = end_y[PW-1:0];
      end
    end
  end

  always_comb begin
    mx       = CW'(in_tile_x) + (in_level[0] ? CW'(PAGE_TILES) : '0);
    my       = CW'(in_tile_y) + (in_level[1] ? CW'(PAGE_TILES) : '0);
    idx      = IW'(my >> 2) * IW'(ROW_WORDS) + IW'(mx >> 2);
    idx_ext  = XW'(idx);
    bi_ext   = XW'(in_block_index);
    mark_hit = (mx < MASK_TILES) && (my < MASK_TILES) && (idx < WORD_COUNT);
    read_hit = (in_block_index < BLOCK_COUNT) && (in_block_index < WORD_COUNT);
    rd_addr  = (req_t'(in_req_type) == REQ_MARK) ? idx_ext[AW-1:0] : bi_ext[AW-1:0];
  end

  always_comb begin
    we = cmd.sweep || (cmd.finish && (req_r == REQ_MARK) && hit_r);
    wa = cmd.sweep ? cnt_r : addr_r;
    wd = cmd.sweep ? '0 : (rd_data_r | (WORD_BITS'(1) << bit_r));
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mask_mem[wa] <= wd;
    end
    if (cmd.take_in) begin
      rd_data_r <= mask_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      req_r  <= req_t'(in_req_type);
      addr_r <= rd_addr;
      bit_r  <= {my[1:0], mx[1:0]};
      hit_r  <= (req_t'(in_req_type) == REQ_MARK) ? mark_hit : read_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_col_r      <= '0;
      pack_row_r      <= '0;
      pack_row_high_r <= '0;
      cnt_r           <= '0;
    end else begin
      if (cmd.sweep) begin
        cnt_r <= stat.sweep_last ? '0 : cnt_r + AW'(1);
      end
      if (cmd.take_in) begin
        if (req_t'(in_req_type) == REQ_RESERVE) begin
          pack_col_r      <= pack_col_nxt;
          pack_row_r      <= pack_row_nxt;
          pack_row_high_r <= pack_row_high_nxt;
        end else if (req_t'(in_req_type) == REQ_CLEAR) begin
          pack_col_r      <= '0;
          pack_row_r      <= '0;
          pack_row_high_r <= '0;
        end
      end
    end
  end

  assign load_res = cmd.take_in && (req_t'(in_req_type) == REQ_RESERVE);
  assign load_fin = cmd.finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (load_res || load_fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      out_status     <= fail;
      out_place_x    <= fail ? '0 : col_use[4:0];
      out_place_y    <= fail ? '0 : row_use[4:0];
      out_block_code <= '0;
    end else if (load_fin) begin
      out_status     <= 1'b0;
      out_place_x    <= '0;
      out_place_y    <= '0;
      if (req_r == REQ_READ) begin
        out_block_code <= encode_word(hit_r ? rd_data_r : '0);
      end else begin
        out_block_code <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tile_shelf_packer_with_mask.sv =====
// Reserve: the result is registered in the cycle after acceptance. Mark and read: one mask
// word is read into a register, then the FIN state loads the result once the output is free.
// One reserve is taken per cycle while the output drains; a mark or read holds the input
// closed until its result is loaded. Clear sweeps the mask memory one word a cycle.
// Reset (rst_n low, synchronous) clears the packer and runs the same sweep; in_ready stays low.
`timescale 1ns / 1ps
`default_nettype none

module tile_shelf_packer_with_mask #(
  parameter int PAGE_TILES  = tsp_pkg::DEF_PAGE_TILES,
  parameter int MASK_TILES  = tsp_pkg::DEF_MASK_TILES,
  parameter int BLOCK_COUNT = tsp_pkg::DEF_BLOCK_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [4:0]  in_region_width,
  input  logic [4:0]  in_region_height,
  input  logic [1:0]  in_level,
  input  logic [4:0]  in_tile_x,
  input  logic [4:0]  in_tile_y,
  input  logic [7:0]  in_block_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [4:0]  out_place_x,
  output logic [4:0]  out_place_y,
  output logic [63:0] out_block_code
);
  import tsp_pkg::*;

  tsp_cmd_t  cmd;
  tsp_stat_t stat;

  tsp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .stat        (stat),
    .cmd         (cmd),
    .in_ready    (in_ready)
  );

  tsp_dp #(
    .PAGE_TILES  (PAGE_TILES),
    .MASK_TILES  (MASK_TILES),
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_req_type      (in_req_type),
    .in_region_width  (in_region_width),
    .in_region_height (in_region_height),
    .in_level         (in_level),
    .in_tile_x        (in_tile_x),
    .in_tile_y        (in_tile_y),
    .in_block_index   (in_block_index),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_place_x      (out_place_x),
    .out_place_y      (out_place_y),
    .out_block_code   (out_block_code)
  );

endmodule

`default_nettype wire

// ===== rtl/tsp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsp_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire        out_status,
  input wire [4:0]  out_place_x,
  input wire [4:0]  out_place_y,
  input wire [63:0] out_block_code
);

  // A held item keeps its code and status until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_block_code) && $stable(out_status))
    else $error("result item changed while stalled");

  // The block only takes an item when the result register is free or draining.
  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_ready)
    else $error("input accepted with a full result register");

  // The mask sweep after reset keeps the input closed.
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open straight after reset");

  // A failed reserve reports no position and no code.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_place_x == 5'd0 && out_place_y == 5'd0
                                && out_block_code == 64'd0)
    else $error("failed reserve carries a position or code");

  // Any non-zero code is a read result with the fixed base pattern.
  a_code_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_code != 64'd0 |-> out_block_code[15:0] == 16'hFF00 && !out_status)
    else $error("malformed block code");

endmodule

bind tile_shelf_packer_with_mask tsp_checker u_tsp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_place_x    (out_place_x),
  .out_place_y    (out_place_y),
  .out_block_code (out_block_code)
);

`default_nettype wire
